/* rtl/core/clem_pkg.sv */
// Shared widths, register indexes, divider iteration counts and sequencer codes for the contour/lag error monitor.
package clem_pkg;

   localparam int AXIS_W   = 31;
   localparam int ERR_W    = 32;
   localparam int REQ_W    = 280;
   localparam int RSP_W    = 248;
   localparam int DVD_W    = 128;
   localparam int DVS_W    = 64;
   localparam int ITER_W   = 8;
   localparam int HEALTH_W = 17;

   // register indexes on the csr port
   localparam logic [1:0] CSR_POSITION_LIMIT = 2'd0;
   localparam logic [1:0] CSR_CONTOUR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_LAG_LIMIT      = 2'd2;

   localparam logic [31:0] LIMIT_RESET = 32'd65536;
   localparam logic [HEALTH_W-1:0] HEALTH_ONE = 17'd65536;

   // divider iteration counts per use
   localparam logic [ITER_W-1:0] ITER_LAG    = 8'd128;
   localparam logic [ITER_W-1:0] ITER_HEALTH = 8'd48;
   localparam logic [ITER_W-1:0] ITER_MEAN   = 8'd32;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL1  = 4'd1;
   localparam logic [3:0] ST_MUL2  = 4'd2;
   localparam logic [3:0] ST_SQP   = 4'd3;
   localparam logic [3:0] ST_DIVL  = 4'd4;
   localparam logic [3:0] ST_SQL   = 4'd5;
   localparam logic [3:0] ST_MULL  = 4'd6;
   localparam logic [3:0] ST_SQC   = 4'd7;
   localparam logic [3:0] ST_STAT  = 4'd8;
   localparam logic [3:0] ST_DIVM  = 4'd9;
   localparam logic [3:0] ST_MEAN  = 4'd10;
   localparam logic [3:0] ST_DIVHP = 4'd11;
   localparam logic [3:0] ST_DIVHC = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

endpackage

/* rtl/core/clem_mult.sv */
// Registered 33x33 signed multiplier shared by all products of the sequencer.
module clem_mult (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] prod_ff
);

   // one product per cycle, result registered
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

/* rtl/core/clem_div.sv */
// Restoring divider, one quotient bit per cycle, dividend pre-aligned to the top bits.
module clem_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [clem_pkg::DVD_W-1:0]     dividend,
   input  logic [clem_pkg::DVS_W-1:0]     divisor,
   input  logic [clem_pkg::ITER_W-1:0]    iters,
   output logic                           busy,
   output logic [63:0]                    quotient
);
   import clem_pkg::*;

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [63:0]       quo_ff;
   logic [ITER_W-1:0] cnt_ff;
   logic              busy_ff;
   logic [DVS_W:0]    trial;
   logic [DVS_W+1:0]  diff;
   logic              ge;

   // trial subtract of the shifted remainder
   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = {1'b0, trial} - {2'b00, dvs_ff};
      ge     = ~diff[DVS_W+1];
      rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= iters;
         rem_ff  <= '0;
         dvd_ff  <= dividend;
         dvs_ff  <= divisor;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         dvd_ff  <= {dvd_ff[DVD_W-2:0], 1'b0};
         quo_ff  <= {quo_ff[62:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == 8'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/clem_sqrt.sv */
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
module clem_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] rad_ff;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [35:0] cur;
   logic [36:0] diff;
   logic        ge;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      cur    = {rem_ff, rad_ff[63:62]};
      diff   = {1'b0, cur} - {3'b000, root_ff, 2'b01};
      ge     = ~diff[36];
      rem_in = ge ? diff[33:0] : cur[33:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[61:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[30:0], ge};
         cnt_ff  <= cnt_ff + 1'b1;
         if (cnt_ff == 6'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

/* rtl/core/contour_lag_error_monitor_unit.sv */
// Top level: sequencer over shared multiplier, divider and square root units.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata  (280b sample)
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata  (248b result)
//  csr     | in  | csr_we                 | csr_index, csr_wdata
//
// Sample time is set by the bit-serial units: the divider runs 128 steps for
// the lag quotient, 32 for the mean and 48 per health term, plus up to three
// 32-step square roots.
// Reset is synchronous; it restores limits to 1.0 mm and clears statistics.
// req_tready is high only while idle; a result waits in the output register
// and the next sample may enter meanwhile.
module contour_lag_error_monitor_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // req_tdata from bit 0: clear_stats, actual_x, actual_y, actual_z,
   // target_x, target_y, target_z, speed_x, speed_y, speed_z
   input  logic [clem_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // rsp_tdata from bit 0: position_error, lag_error, contour_error,
   // position_alert, contour_alert, lag_alert, health_score, sample_count,
   // error_min, error_max, error_mean, zero fill
   output logic [clem_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_wdata
);
   import clem_pkg::*;

   logic [3:0]                state_ff;
   logic                      ph_ff;
   logic [3:0]                k_ff;
   logic                      clear_ff;
   logic signed [ERR_W-1:0]   e_ff [3];
   logic signed [AXIS_W-1:0]  v_ff [3];
   logic [63:0]               e2_ff, v2_ff, l2_ff;
   logic signed [63:0]        dot_ff;
   logic [127:0]              dsq_ff;
   logic [31:0]               pos_ff, lag_ff, cont_ff;
   logic                      dneg_ff;
   logic [HEALTH_W-1:0]       hp_ff, hc_ff;
   logic [31:0]               count_ff, min_ff, max_ff, mean_ff;
   logic [31:0]               plim_ff, clim_ff, llim_ff;
   logic                      rsp_valid_ff;
   logic [RSP_W-1:0]          rsp_data_ff;

   logic signed [32:0]        mul_a, mul_b;
   logic signed [65:0]        prod;
   logic                      div_start, div_busy;
   logic [DVD_W-1:0]          div_dvd;
   logic [DVS_W-1:0]          div_dvs;
   logic [ITER_W-1:0]         div_iters;
   logic [63:0]               quo;
   logic                      sq_start, sq_busy;
   logic [63:0]               sq_rad;
   logic [31:0]               sq_root;
   logic [62:0]               dmag;
   logic [32:0]               lag_bits;
   logic [HEALTH_W-1:0]       health;
   logic [HEALTH_W-1:0]       hterm;
   logic                      accept;

   clem_mult u_mult (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));

   clem_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .iters(div_iters), .busy(div_busy), .quotient(quo)
   );

   clem_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .busy(sq_busy), .root(sq_root)
   );

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign dmag       = dot_ff[63] ? 63'(-dot_ff) : dot_ff[62:0];

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL1: begin
            case (k_ff)
               4'd0: begin mul_a = 33'(e_ff[0]); mul_b = 33'(e_ff[0]); end
               4'd1: begin mul_a = 33'(e_ff[1]); mul_b = 33'(e_ff[1]); end
               4'd2: begin mul_a = 33'(e_ff[2]); mul_b = 33'(e_ff[2]); end
               4'd3: begin mul_a = 33'(v_ff[0]); mul_b = 33'(v_ff[0]); end
               4'd4: begin mul_a = 33'(v_ff[1]); mul_b = 33'(v_ff[1]); end
               4'd5: begin mul_a = 33'(v_ff[2]); mul_b = 33'(v_ff[2]); end
               4'd6: begin mul_a = 33'(e_ff[0]); mul_b = 33'(v_ff[0]); end
               4'd7: begin mul_a = 33'(e_ff[1]); mul_b = 33'(v_ff[1]); end
               4'd8: begin mul_a = 33'(e_ff[2]); mul_b = 33'(v_ff[2]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_MUL2: begin
            // |dot| split into a = bits 62:32 and b = bits 31:0
            case (k_ff)
               4'd0: begin mul_a = {2'b00, dmag[62:32]}; mul_b = {2'b00, dmag[62:32]}; end
               4'd1: begin mul_a = {2'b00, dmag[62:32]}; mul_b = {1'b0, dmag[31:0]}; end
               4'd2: begin mul_a = {1'b0, dmag[31:0]}; mul_b = {1'b0, dmag[31:0]}; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_MULL: begin
            mul_a = {1'b0, lag_ff};
            mul_b = {1'b0, lag_ff};
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // divider and square root request select
   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      div_iters = ITER_MEAN;
      sq_start  = 1'b0;
      sq_rad    = '0;
      case (state_ff)
         ST_DIVL: begin
            div_start = ~ph_ff;
            div_dvd   = dsq_ff;
            div_dvs   = v2_ff;
            div_iters = ITER_LAG;
         end
         ST_DIVM: begin
            div_start = ~ph_ff;
            div_dvd   = {(pos_ff < mean_ff) ? mean_ff - pos_ff : pos_ff - mean_ff, 96'd0};
            div_dvs   = {32'd0, count_ff};
            div_iters = ITER_MEAN;
         end
         ST_DIVHP: begin
            div_start = ~ph_ff & (plim_ff != 32'd0);
            div_dvd   = {pos_ff, 16'd0, 80'd0};
            div_dvs   = {32'd0, plim_ff};
            div_iters = ITER_HEALTH;
         end
         ST_DIVHC: begin
            div_start = ~ph_ff & (clim_ff != 32'd0);
            div_dvd   = {cont_ff, 16'd0, 80'd0};
            div_dvs   = {32'd0, clim_ff};
            div_iters = ITER_HEALTH;
         end
         ST_SQP: begin
            sq_start = ~ph_ff;
            sq_rad   = e2_ff;
         end
         ST_SQL: begin
            sq_start = ~ph_ff;
            sq_rad   = quo;
         end
         ST_SQC: begin
            sq_start = ~ph_ff;
            sq_rad   = (e2_ff > l2_ff) ? e2_ff - l2_ff : 64'd0;
         end
         default: begin
            div_start = 1'b0;
            sq_start  = 1'b0;
         end
      endcase
   end

   // health term from a finished ratio quotient
   assign hterm    = (quo < 64'd65536) ? HEALTH_ONE - quo[HEALTH_W-1:0] : '0;
   assign health   = (hp_ff < hc_ff) ? hp_ff : hc_ff;
   assign lag_bits = dneg_ff ? 33'd0 - {1'b0, lag_ff} : {1'b0, lag_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         plim_ff <= LIMIT_RESET;
         clim_ff <= LIMIT_RESET;
         llim_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POSITION_LIMIT: plim_ff <= csr_wdata;
            CSR_CONTOUR_LIMIT:  clim_ff <= csr_wdata;
            CSR_LAG_LIMIT:      llim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         mean_ff      <= '0;
      end else begin
         // result beat taken; the output state reloads it itself
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  clear_ff <= req_tdata[0];
                  e_ff[0]  <= ERR_W'(signed'(req_tdata[31:1]))
                            - ERR_W'(signed'(req_tdata[124:94]));
                  e_ff[1]  <= ERR_W'(signed'(req_tdata[62:32]))
                            - ERR_W'(signed'(req_tdata[155:125]));
                  e_ff[2]  <= ERR_W'(signed'(req_tdata[93:63]))
                            - ERR_W'(signed'(req_tdata[186:156]));
                  v_ff[0]  <= req_tdata[217:187];
                  v_ff[1]  <= req_tdata[248:218];
                  v_ff[2]  <= req_tdata[279:249];
                  e2_ff    <= '0;
                  v2_ff    <= '0;
                  dot_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               // product for step k-1 lands this cycle
               case (k_ff)
                  4'd1, 4'd2, 4'd3: e2_ff <= e2_ff + prod[63:0];
                  4'd4, 4'd5, 4'd6: v2_ff <= v2_ff + prod[63:0];
                  4'd7, 4'd8, 4'd9: dot_ff <= dot_ff + prod[63:0];
                  default: ;
               endcase
               if (k_ff == 4'd9) begin
                  k_ff     <= '0;
                  state_ff <= ST_MUL2;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_MUL2: begin
               case (k_ff)
                  4'd1: dsq_ff <= {prod[63:0], 64'd0};
                  4'd2: dsq_ff <= dsq_ff + {31'd0, prod[63:0], 33'd0};
                  4'd3: dsq_ff <= dsq_ff + {64'd0, prod[63:0]};
                  default: ;
               endcase
               if (k_ff == 4'd3) begin
                  state_ff <= ST_SQP;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_SQP: begin
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else if (!sq_busy) begin
                  ph_ff   <= 1'b0;
                  pos_ff  <= sq_root;
                  dneg_ff <= dot_ff[63];
                  if (v2_ff == 64'd0) begin
                     lag_ff   <= '0;
                     cont_ff  <= sq_root;
                     state_ff <= ST_STAT;
                  end else begin
                     state_ff <= ST_DIVL;
                  end
               end
            end
            ST_DIVL: begin
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else if (!div_busy) begin
                  ph_ff    <= 1'b0;
                  state_ff <= ST_SQL;
               end
            end
            ST_SQL: begin
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else if (!sq_busy) begin
                  ph_ff    <= 1'b0;
                  lag_ff   <= sq_root;
                  state_ff <= ST_MULL;
               end
            end
            ST_MULL: begin
               // operands presented now, square ready next cycle
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else begin
                  ph_ff    <= 1'b0;
                  l2_ff    <= prod[63:0];
                  state_ff <= ST_SQC;
               end
            end
            ST_SQC: begin
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else if (!sq_busy) begin
                  ph_ff    <= 1'b0;
                  cont_ff  <= sq_root;
                  state_ff <= ST_STAT;
               end
            end
            ST_STAT: begin
               // optional clear, then fold in count, min and max
               if (clear_ff) begin
                  count_ff <= 32'd1;
                  min_ff   <= pos_ff;
                  max_ff   <= pos_ff;
                  mean_ff  <= '0;
               end else begin
                  if (count_ff != 32'hFFFF_FFFF) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (pos_ff < min_ff) begin
                     min_ff <= pos_ff;
                  end
                  if (pos_ff > max_ff) begin
                     max_ff <= pos_ff;
                  end
               end
               state_ff <= ST_DIVM;
            end
            ST_DIVM: begin
               if (!ph_ff) begin
                  ph_ff <= 1'b1;
               end else if (!div_busy) begin
                  ph_ff    <= 1'b0;
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               if (pos_ff < mean_ff) begin
                  mean_ff <= mean_ff - quo[31:0];
               end else begin
                  mean_ff <= mean_ff + quo[31:0];
               end
               state_ff <= ST_DIVHP;
            end
            ST_DIVHP: begin
               if (!ph_ff) begin
                  if (plim_ff == 32'd0) begin
                     hp_ff    <= '0;
                     state_ff <= ST_DIVHC;
                  end else begin
                     ph_ff <= 1'b1;
                  end
               end else if (!div_busy) begin
                  ph_ff    <= 1'b0;
                  hp_ff    <= hterm;
                  state_ff <= ST_DIVHC;
               end
            end
            ST_DIVHC: begin
               if (!ph_ff) begin
                  if (clim_ff == 32'd0) begin
                     hc_ff    <= '0;
                     state_ff <= ST_OUT;
                  end else begin
                     ph_ff <= 1'b1;
                  end
               end else if (!div_busy) begin
                  ph_ff    <= 1'b0;
                  hc_ff    <= hterm;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // load the output register once it is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {3'd0, mean_ff, max_ff, min_ff, count_ff, health,
                                   (lag_ff > llim_ff), (cont_ff > clim_ff),
                                   (pos_ff > plim_ff), cont_ff, lag_bits, pos_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* verif/clem_checker.sv */
// Checker for the contour/lag error monitor: predicts every result and compares beats.
`timescale 1ns / 100ps

module clem_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [clem_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [clem_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_wdata,
   output int                         errors,
   output int                         pending,
   output int                         results_seen,
   output int                         alerts_seen
);
   import clem_pkg::*;

   localparam int RING_DEPTH = 8;

   typedef struct packed {
      logic [31:0] pos;
      logic [32:0] lag;
      logic [31:0] contour;
      logic        pos_alert;
      logic        contour_alert;
      logic        lag_alert;
      logic [16:0] health;
      logic [31:0] count;
      logic [31:0] err_min;
      logic [31:0] err_max;
      logic [31:0] err_mean;
   } error_report_type;

   // expected reports in arrival order
   error_report_type expected_reports [RING_DEPTH];
   int wr_count, rd_count;

   logic [31:0] pos_limit, contour_lim, lag_lim;
   logic [31:0] stat_count, stat_min, stat_max, stat_mean;

   assign pending = wr_count - rd_count;

   // floor of square root, bit by bit
   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [16:0] health_of(logic [63:0] err, logic [31:0] limit);
      logic [63:0] ratio;
      if (limit == 0) return 0;
      ratio = (err << 16) / limit;
      return (ratio < 64'd65536) ? 17'(65536 - ratio) : 17'd0;
   endfunction

   // one sample in, statistics updated, report returned
   function automatic error_report_type assess_sample(logic [REQ_W-1:0] d);
      error_report_type rep;
      longint ex, vx, dot;
      logic [63:0] e2, v2, ea, va, pos, lag_mag, contour, l2, dmag, q;
      logic [127:0] dsq;
      logic [63:0] delta_mag;
      logic [16:0] hp, hc;
      dot = 0;
      e2 = 0;
      v2 = 0;
      lag_mag = 0;
      for (int i = 0; i < 3; i++) begin
         ex = longint'($signed(d[1 + 31*i +: 31])) - longint'($signed(d[94 + 31*i +: 31]));
         vx = longint'($signed(d[187 + 31*i +: 31]));
         ea = (ex < 0) ? 64'(-ex) : 64'(ex);
         va = (vx < 0) ? 64'(-vx) : 64'(vx);
         e2 = e2 + ea * ea;
         v2 = v2 + va * va;
         dot = dot + ex * vx;
      end
      pos = floor_sqrt(e2);
      rep.lag = 0;
      if (v2 != 0) begin
         dmag = (dot < 0) ? 64'(-dot) : 64'(dot);
         dsq = 128'(dmag) * 128'(dmag);
         q = 64'(dsq / 128'(v2));
         lag_mag = floor_sqrt(q);
         l2 = lag_mag * lag_mag;
         contour = floor_sqrt(e2 > l2 ? e2 - l2 : 64'd0);
         rep.lag = (dot < 0) ? 33'(-lag_mag) : 33'(lag_mag);
      end else begin
         contour = pos;
      end

      // statistics, cleared first when asked
      if (d[0]) begin
         stat_count = 0;
         stat_min = '1;
         stat_max = 0;
         stat_mean = 0;
      end
      if (stat_count != '1) stat_count = stat_count + 1;
      if (pos < stat_min) stat_min = pos[31:0];
      if (pos > stat_max) stat_max = pos[31:0];
      if (pos < stat_mean) begin
         delta_mag = 64'(stat_mean) - pos;
         stat_mean = 32'(64'(stat_mean) - delta_mag / stat_count);
      end else begin
         delta_mag = pos - 64'(stat_mean);
         stat_mean = 32'(64'(stat_mean) + delta_mag / stat_count);
      end

      hp = health_of(pos, pos_limit);
      hc = health_of(contour, contour_lim);
      rep.pos = pos[31:0];
      rep.contour = contour[31:0];
      rep.pos_alert = pos > pos_limit;
      rep.contour_alert = contour > contour_lim;
      rep.lag_alert = lag_mag > lag_lim;
      rep.health = (hp < hc) ? hp : hc;
      rep.count = stat_count;
      rep.err_min = stat_min;
      rep.err_max = stat_max;
      rep.err_mean = stat_mean;
      return rep;
   endfunction

   always @(posedge clock) begin
      error_report_type want;
      if (reset) begin
         pos_limit <= LIMIT_RESET;
         contour_lim <= LIMIT_RESET;
         lag_lim <= LIMIT_RESET;
         stat_count = 0;
         stat_min = '1;
         stat_max = 0;
         stat_mean = 0;
         wr_count = 0;
         rd_count = 0;
         errors = 0;
         results_seen = 0;
         alerts_seen = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_POSITION_LIMIT: pos_limit <= csr_wdata;
               CSR_CONTOUR_LIMIT:  contour_lim <= csr_wdata;
               CSR_LAG_LIMIT:      lag_lim <= csr_wdata;
               default: ;
            endcase
         end
         // accepted sample beat
         if (req_tvalid && req_tready) begin
            if (wr_count - rd_count >= RING_DEPTH) begin
               $display("%0t: too many samples pending, exp at most %0d got %0d", $realtime,
                        RING_DEPTH, wr_count - rd_count + 1);
               errors++;
            end else begin
               expected_reports[wr_count % RING_DEPTH] = assess_sample(req_tdata);
               wr_count++;
            end
         end
         // accepted result beat
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (wr_count == rd_count) begin
               $display("%0t: result beat with no sample pending: exp none got %h",
                        $realtime, rsp_tdata);
               errors++;
            end else begin
               want = expected_reports[rd_count % RING_DEPTH];
               rd_count++;
               if (rsp_tdata[31:0] != want.pos) begin
                  $display("%0t: position_error exp %0d got %0d", $realtime, want.pos,
                           rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[64:32] != want.lag) begin
                  $display("%0t: lag_error exp %h got %h", $realtime, want.lag, rsp_tdata[64:32]);
                  errors++;
               end
               if (rsp_tdata[96:65] != want.contour) begin
                  $display("%0t: contour_error exp %0d got %0d", $realtime, want.contour,
                           rsp_tdata[96:65]);
                  errors++;
               end
               if (rsp_tdata[99:97] != {want.lag_alert, want.contour_alert, want.pos_alert}) begin
                  $display("%0t: alerts (lag,contour,pos) exp %b got %b", $realtime,
                           {want.lag_alert, want.contour_alert, want.pos_alert},
                           rsp_tdata[99:97]);
                  errors++;
               end
               if (rsp_tdata[116:100] != want.health) begin
                  $display("%0t: health_score exp %0d got %0d", $realtime, want.health,
                           rsp_tdata[116:100]);
                  errors++;
               end
               if (rsp_tdata[148:117] != want.count) begin
                  $display("%0t: sample_count exp %0d got %0d", $realtime, want.count,
                           rsp_tdata[148:117]);
                  errors++;
               end
               if (rsp_tdata[180:149] != want.err_min) begin
                  $display("%0t: error_min exp %0d got %0d", $realtime, want.err_min,
                           rsp_tdata[180:149]);
                  errors++;
               end
               if (rsp_tdata[212:181] != want.err_max) begin
                  $display("%0t: error_max exp %0d got %0d", $realtime, want.err_max,
                           rsp_tdata[212:181]);
                  errors++;
               end
               if (rsp_tdata[244:213] != want.err_mean) begin
                  $display("%0t: error_mean exp %0d got %0d", $realtime, want.err_mean,
                           rsp_tdata[244:213]);
                  errors++;
               end
               if (want.pos_alert || want.contour_alert || want.lag_alert) alerts_seen++;
            end
         end
      end
   end

endmodule

/* verif/testbench.sv */
// Testbench top: clock, reset, sample and register stimulus, and the verdict.
`timescale 1ns / 100ps

module testbench;
   import clem_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SAMPLES_PER_PHASE = 150;

   logic             clock;
   logic             reset;
   logic             req_tvalid, req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [31:0]      csr_wdata;

   int  errors, pending, results_seen, alerts_seen;
   int  cycles, settings_used;
   bit  no_gaps;

   contour_lag_error_monitor_unit u_top (.*);

   clem_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side backpressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic logic [REQ_W-1:0] pack_sample(bit clr, logic signed [30:0] f[9]);
      logic [REQ_W-1:0] d;
      d = '0;
      d[0] = clr;
      for (int i = 0; i < 9; i++) d[1 + 31*i +: 31] = f[i];
      return d;
   endfunction

   // one sample beat, valid kept high after acceptance
   task automatic send_sample(logic [REQ_W-1:0] d);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // wait for every result, then let the unit settle
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(logic [1:0] idx, logic [31:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_limits(logic [31:0] p, logic [31:0] c, logic [31:0] l);
      settle();
      write_limit(CSR_POSITION_LIMIT, p);
      write_limit(CSR_CONTOUR_LIMIT, c);
      write_limit(CSR_LAG_LIMIT, l);
      settings_used++;
   endtask

   function automatic logic signed [30:0] rand_axis();
      return 31'($urandom);
   endfunction

   // mostly near-target positions with random scale; some wild ones
   task automatic random_sample();
      logic signed [30:0] f[9];
      int scale, mode;
      longint off;
      scale = $urandom_range(0, 24);
      for (int i = 0; i < 3; i++) begin
         f[3+i] = rand_axis();
         off = longint'($urandom_range(0, 1 << scale));
         if ($urandom_range(0, 1)) off = -off;
         f[i] = ($urandom_range(0, 15) == 0) ? rand_axis() : 31'(longint'(f[3+i]) + off);
      end
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         case (mode)
            0: f[6+i] = 0;
            1: f[6+i] = (i == 0) ? rand_axis() : 31'sd0;
            2: f[6+i] = 31'($signed($urandom_range(0, 7)) - 3);
            default: f[6+i] = rand_axis();
         endcase
      end
      send_sample(pack_sample($urandom_range(0, 19) == 0, f));
   endtask

   task automatic directed_samples();
      logic signed [30:0] f[9];
      logic signed [30:0] hi, lo;
      hi = 31'sh3FFFFFFF;
      lo = 31'sh40000000;
      // largest error on every axis, largest speeds
      f = '{hi, hi, hi, lo, lo, lo, hi, hi, hi};
      send_sample(pack_sample(1'b0, f));
      f = '{lo, lo, lo, hi, hi, hi, lo, lo, lo};
      send_sample(pack_sample(1'b0, f));
      f = '{lo, hi, lo, hi, lo, hi, hi, lo, hi};
      send_sample(pack_sample(1'b0, f));
      // zero velocity: contour equals position error, lag zero
      f = '{hi, 0, lo, lo, 0, hi, 0, 0, 0};
      send_sample(pack_sample(1'b0, f));
      f = '{31'sd65536, 0, 0, 0, 0, 0, 0, 0, 0};
      send_sample(pack_sample(1'b0, f));
      // zero error
      f = '{5, -7, 9, 5, -7, 9, hi, lo, 1};
      send_sample(pack_sample(1'b1, f));
      f = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_sample(pack_sample(1'b0, f));
      // error along and across the motion, smallest speed
      f = '{31'sd131072, 0, 0, 0, 0, 0, 1, 0, 0};
      send_sample(pack_sample(1'b0, f));
      f = '{0, 31'sd131072, 0, 0, 0, 0, -1, 0, 0};
      send_sample(pack_sample(1'b0, f));
      f = '{-31'sd200000, 31'sd70000, 0, 0, 0, 0, 0, 0, lo};
      send_sample(pack_sample(1'b0, f));
      f = '{31'sd65536, 31'sd65536, 31'sd65536, 0, 0, 0, 3, -4, 12};
      send_sample(pack_sample(1'b1, f));
      // actual and speed fields all ones, then target and speed fields all ones
      f = '{-1, -1, -1, 0, 0, 0, -1, -1, -1};
      send_sample(pack_sample(1'b1, f));
      f = '{0, 0, 0, -1, -1, -1, -1, -1, -1};
      send_sample(pack_sample(1'b0, f));
      f = '{31'sd65537, 0, 0, 0, 0, 0, 0, 31'sd1000, 0};
      send_sample(pack_sample(1'b0, f));
   endtask

   initial begin
      logic [31:0] rp, rc, rl;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_POSITION_LIMIT;
      csr_wdata = '0;
      settings_used = 1;
      no_gaps = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // default limits first
      directed_samples();
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) random_sample();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_limits(32'd1, 32'd1, 32'd1);
            1: set_limits('1, '1, '1);
            2: set_limits(32'd0, 32'd0, 32'd0);
            3: begin
               set_limits(32'd65536, 32'd32768, 32'd131072);
               // write to an unmapped index is dropped
               write_limit(CSR_UNUSED, 32'd7);
            end
            default: begin
               rp = 32'd1 << $urandom_range(0, 24);
               rc = $urandom_range(1, 1 << 22);
               rl = $urandom;
               set_limits(rp, rc, rl);
            end
         endcase
         no_gaps = (phase == 1 || phase == 4);
         if (phase == 2) directed_samples();
         for (int n = 0; n < SAMPLES_PER_PHASE; n++) random_sample();
      end

      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d samples (%0d with alerts) over %0d limit settings",
               results_seen, alerts_seen, settings_used);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
